>>> hdl/pdre_pkg.sv
// Shared constants, register codes and saturation helpers of the reprojection error pipeline.
package pdre_pkg;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X = 4'd0,
    REG_FOCAL_Y = 4'd1,
    REG_CENTER_X = 4'd2,
    REG_CENTER_Y = 4'd3,
    REG_RADIAL_K1 = 4'd4,
    REG_RADIAL_K2 = 4'd5,
    REG_TANG_P1 = 4'd6,
    REG_TANG_P2 = 4'd7
  } cfg_reg_e;

  localparam logic [27:0] FOCAL_RESET = 28'd16384000;
  localparam logic signed [32:0] DEPTH_OFFSET = 33'sd655;

  // Fraction bits of the normalized coordinates and the coefficients.
  localparam int QFRAC = 28;

  // Divider geometry: quotient magnitude bits and divisor width.
  localparam int NUM_W = 32;
  localparam int DEN_W = 33;
  localparam int QUO_W = 32;
  localparam int DIV_STAGES = 32;

  // Widths of the intermediate quantities, sized from their worst case.
  localparam int W_X = 32;
  localparam int W_XX = 36;
  localparam int W_R2 = 38;
  localparam int W_R4 = 44;
  localparam int W_K = 42;
  localparam int W_K2R4 = 48;
  localparam int W_RAD = 49;
  localparam int W_XR = 51;
  localparam int W_XD = 52;
  localparam int W_FXD = 53;
  localparam int W_PX = 54;

  // Turns an unsigned quotient magnitude into a saturated signed Q4.28 value.
  function automatic logic signed [31:0] sat_quot(input logic [31:0] q, input logic ovf,
                                                  input logic neg);
    logic big;
    big = ovf | q[31];
    if (neg) begin
      sat_quot = big ? 32'sh8000_0000 : $signed(-q);
    end else begin
      sat_quot = big ? 32'sh7fff_ffff : $signed(q);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [W_PX-1:0] v);
    if ((&v[W_PX-1:31]) || !(|v[W_PX-1:31])) begin
      sat32 = v[31:0];
    end else begin
      sat32 = v[W_PX-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  endfunction

endpackage

>>> hdl/pdre_div.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow detection.
module pdre_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [pdre_pkg::NUM_W-1:0]     num_i,
  input  logic [pdre_pkg::DEN_W-1:0]     den_i,
  output logic [pdre_pkg::QUO_W-1:0]     quo_o,
  output logic                           ovf_o
);

  localparam int S = pdre_pkg::DIV_STAGES;
  localparam int DW = pdre_pkg::DEN_W;
  localparam int QW = pdre_pkg::QUO_W;
  localparam int NW = pdre_pkg::NUM_W;

  logic [DW-1:0] rem_q [S-1];
  logic [DW-1:0] den_q [S-1];
  logic [3:0]    nib_q [S-1];
  logic [QW-1:0] quo_q [S];
  logic          ovf_q [S];

  logic [DW-1:0] r_in  [S];
  logic [DW-1:0] d_in  [S];
  logic [3:0]    n_in  [S];
  logic [QW-1:0] q_in  [S];
  logic          o_in  [S];
  logic [DW:0]   t     [S];
  logic          ge    [S];
  logic [DW-1:0] rem_d [S];
  logic [3:0]    nib_d [S];
  logic [QW-1:0] quo_d [S];

  // The dividend is the magnitude shifted up by 28 bits, so its low 28 bits are zero;
  // the first stage starts from the upper part and flags a quotient of 2^32 or more.
  always_comb begin
    for (int k = 0; k < S; k++) begin
      if (k == 0) begin
        r_in[k] = {{(DW-NW+4){1'b0}}, num_i[NW-1:4]};
        d_in[k] = den_i;
        n_in[k] = num_i[3:0];
        q_in[k] = '0;
        o_in[k] = ({{(DW-NW+4){1'b0}}, num_i[NW-1:4]} >= den_i);
      end else begin
        r_in[k] = rem_q[k-1];
        d_in[k] = den_q[k-1];
        n_in[k] = nib_q[k-1];
        q_in[k] = quo_q[k-1];
        o_in[k] = ovf_q[k-1];
      end
      t[k]     = {r_in[k], n_in[k][3]};
      ge[k]    = (t[k] >= {1'b0, d_in[k]});
      rem_d[k] = ge[k] ? DW'(t[k] - {1'b0, d_in[k]}) : t[k][DW-1:0];
      nib_d[k] = {n_in[k][2:0], 1'b0};
      quo_d[k] = {q_in[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < S; k++) begin
        quo_q[k] <= quo_d[k];
        ovf_q[k] <= o_in[k];
        if (k < S - 1) begin
          rem_q[k] <= rem_d[k];
          den_q[k] <= d_in[k];
          nib_q[k] <= nib_d[k];
        end
      end
    end
  end

  assign quo_o = quo_q[S-1];
  assign ovf_o = ovf_q[S-1];

endmodule

>>> hdl/pdre_qmul.sv
// Two-stage fixed point multiplier: product shifted right by 28 with truncation toward zero.
module pdre_qmul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int WR = 36
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WR-1:0] r_o
);

  localparam int QF = pdre_pkg::QFRAC;
  localparam int H = WB / 2;
  localparam int WP = (WA + WB > WR + QF) ? WA + WB : WR + QF;

  logic signed [WA+H:0]       lo_q;
  logic signed [WA+WB-H-1:0]  hi_q;
  logic signed [WP-1:0]       prod;
  logic signed [WP-1:0]       bias;
  logic signed [WP-1:0]       sum;
  logic signed [WR-1:0]       r_q;

  // The wide operand is split in two halves whose partial products are registered and then summed.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= a_i * $signed({1'b0, b_i[H-1:0]});
      hi_q <= a_i * $signed(b_i[WB-1:H]);
    end
  end

  always_comb begin
    prod = (WP'(hi_q) <<< H) + WP'(lo_q);
    bias = prod[WP-1] ? $signed({{(WP-QF){1'b0}}, {QF{1'b1}}}) : '0;
    sum  = prod + bias;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= WR'(sum >>> QF);
    end
  end

  assign r_o = r_q;

endmodule

>>> hdl/pinhole_distortion_reprojection_error_top.sv
// Top level of the pinhole projection and lens distortion reprojection error pipeline.
// One point is accepted per clock cycle unless a held result stalls the pipeline; its
// errors pass through the 32 stage restoring divider that forms the normalized
// coordinates, followed by five multiplier stages and the sums between them.
// A stalled result freezes the whole pipeline, so no item is dropped or repeated.
// Configuration writes are taken at once; write them only while the pipeline is empty.
module pinhole_distortion_reprojection_error_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                point_fwd_i,
  input  logic signed [31:0]                point_left_i,
  input  logic signed [31:0]                point_up_i,
  input  logic [11:0]                       pixel_row_i,
  input  logic [11:0]                       pixel_col_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                err_col_o,
  output logic signed [31:0]                err_row_o,
  output logic                              depth_zero_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pdre_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int LAT = 48;
  localparam int DS = pdre_pkg::DIV_STAGES;
  localparam int QF = pdre_pkg::QFRAC;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic        zero;
    logic        negx;
    logic        negy;
  } side_t;

  typedef struct packed {
    logic signed [pdre_pkg::W_K-1:0] p1xy;
    logic signed [pdre_pkg::W_K-1:0] p2xy;
    logic signed [pdre_pkg::W_K-1:0] p2tx;
    logic signed [pdre_pkg::W_K-1:0] p1ty;
  } tang_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } coord_t;

  // Configuration registers.
  logic [27:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic signed [31:0] k1_q, k2_q, p1_q, p2_q;

  logic           en;
  logic [LAT-1:0] v_q;

  // Input stage.
  logic signed [32:0] depth_s;
  logic [32:0]        dmag_c;
  logic [31:0]        lmag_c, umag_c;
  logic [32:0]        dmag_q;
  logic [31:0]        lmag_q, umag_q;
  side_t              side_c;
  side_t              sd_q [LAT-1];

  logic [31:0] quo_x, quo_y;
  logic        ovf_x, ovf_y;

  logic signed [31:0] x_q, y_q;
  logic signed [pdre_pkg::W_XX-1:0] xx, yy, xy;
  logic signed [pdre_pkg::W_R2-1:0] r2_d, tx_d, ty_d;
  logic signed [pdre_pkg::W_R2-1:0] r2_q, tx_q, ty_q;
  logic signed [pdre_pkg::W_XX-1:0] xy_q;
  coord_t                           xyc_q [8];

  logic signed [pdre_pkg::W_R4-1:0] r4;
  logic signed [pdre_pkg::W_K-1:0]  k1r2, p1xy, p2xy, p2tx, p1ty;
  logic signed [pdre_pkg::W_K-1:0]  k1r2_q [2];
  tang_t                            tg_q [5];
  logic signed [pdre_pkg::W_K2R4-1:0] k2r4;
  logic signed [pdre_pkg::W_RAD-1:0]  radial_q;
  logic signed [pdre_pkg::W_XR-1:0]   xr, yr;
  logic signed [pdre_pkg::W_XD-1:0]   xd_q, yd_q;
  logic signed [pdre_pkg::W_FXD-1:0]  fxd, fyd;
  logic signed [pdre_pkg::W_PX-1:0]   ecol, erow;

  logic signed [31:0] err_col_q, err_row_q;
  logic               zero_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= pdre_pkg::FOCAL_RESET;
      focal_y_q  <= pdre_pkg::FOCAL_RESET;
      center_x_q <= '0;
      center_y_q <= '0;
      k1_q       <= '0;
      k2_q       <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pdre_pkg::REG_FOCAL_X:   focal_x_q  <= cfg_data_i[27:0];
        pdre_pkg::REG_FOCAL_Y:   focal_y_q  <= cfg_data_i[27:0];
        pdre_pkg::REG_CENTER_X:  center_x_q <= cfg_data_i[27:0];
        pdre_pkg::REG_CENTER_Y:  center_y_q <= cfg_data_i[27:0];
        pdre_pkg::REG_RADIAL_K1: k1_q       <= $signed(cfg_data_i);
        pdre_pkg::REG_RADIAL_K2: k2_q       <= $signed(cfg_data_i);
        pdre_pkg::REG_TANG_P1:   p1_q       <= $signed(cfg_data_i);
        pdre_pkg::REG_TANG_P2:   p2_q       <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held back.
  assign en         = !(v_q[LAT-1] && out_stall_i);
  assign in_stall_o = v_q[LAT-1] && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // The camera frame point is (-left, -up, depth); the quotient sign follows from that.
  always_comb begin
    depth_s = $signed({point_fwd_i[31], point_fwd_i}) + pdre_pkg::DEPTH_OFFSET;
    dmag_c  = depth_s[32] ? -depth_s : depth_s;
    lmag_c  = point_left_i[31] ? -point_left_i : point_left_i;
    umag_c  = point_up_i[31] ? -point_up_i : point_up_i;
    side_c.row  = pixel_row_i;
    side_c.col  = pixel_col_i;
    side_c.zero = (depth_s == '0);
    side_c.negx = (!point_left_i[31] && (point_left_i != '0)) ^ depth_s[32];
    side_c.negy = (!point_up_i[31] && (point_up_i != '0)) ^ depth_s[32];
  end

  pdre_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (lmag_q),
    .den_i (dmag_q),
    .quo_o (quo_x),
    .ovf_o (ovf_x)
  );

  pdre_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (umag_q),
    .den_i (dmag_q),
    .quo_o (quo_y),
    .ovf_o (ovf_y)
  );

  pdre_qmul #(.WA(32), .WB(32), .WR(pdre_pkg::W_XX)) u_mul_xx (
    .clk_i(clk_i), .en_i(en), .a_i(x_q), .b_i(x_q), .r_o(xx));
  pdre_qmul #(.WA(32), .WB(32), .WR(pdre_pkg::W_XX)) u_mul_yy (
    .clk_i(clk_i), .en_i(en), .a_i(y_q), .b_i(y_q), .r_o(yy));
  pdre_qmul #(.WA(32), .WB(32), .WR(pdre_pkg::W_XX)) u_mul_xy (
    .clk_i(clk_i), .en_i(en), .a_i(x_q), .b_i(y_q), .r_o(xy));

  always_comb begin
    r2_d = pdre_pkg::W_R2'(xx) + pdre_pkg::W_R2'(yy);
    tx_d = r2_d + (pdre_pkg::W_R2'(xx) <<< 1);
    ty_d = r2_d + (pdre_pkg::W_R2'(yy) <<< 1);
  end

  pdre_qmul #(.WA(pdre_pkg::W_R2), .WB(pdre_pkg::W_R2), .WR(pdre_pkg::W_R4)) u_mul_r4 (
    .clk_i(clk_i), .en_i(en), .a_i(r2_q), .b_i(r2_q), .r_o(r4));
  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_R2), .WR(pdre_pkg::W_K)) u_mul_k1 (
    .clk_i(clk_i), .en_i(en), .a_i(k1_q), .b_i(r2_q), .r_o(k1r2));
  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_XX), .WR(pdre_pkg::W_K)) u_mul_p1xy (
    .clk_i(clk_i), .en_i(en), .a_i(p1_q), .b_i(xy_q), .r_o(p1xy));
  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_XX), .WR(pdre_pkg::W_K)) u_mul_p2xy (
    .clk_i(clk_i), .en_i(en), .a_i(p2_q), .b_i(xy_q), .r_o(p2xy));
  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_R2), .WR(pdre_pkg::W_K)) u_mul_p2tx (
    .clk_i(clk_i), .en_i(en), .a_i(p2_q), .b_i(tx_q), .r_o(p2tx));
  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_R2), .WR(pdre_pkg::W_K)) u_mul_p1ty (
    .clk_i(clk_i), .en_i(en), .a_i(p1_q), .b_i(ty_q), .r_o(p1ty));

  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_R4), .WR(pdre_pkg::W_K2R4)) u_mul_k2 (
    .clk_i(clk_i), .en_i(en), .a_i(k2_q), .b_i(r4), .r_o(k2r4));

  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_RAD), .WR(pdre_pkg::W_XR)) u_mul_xr (
    .clk_i(clk_i), .en_i(en), .a_i(xyc_q[7].x), .b_i(radial_q), .r_o(xr));
  pdre_qmul #(.WA(32), .WB(pdre_pkg::W_RAD), .WR(pdre_pkg::W_XR)) u_mul_yr (
    .clk_i(clk_i), .en_i(en), .a_i(xyc_q[7].y), .b_i(radial_q), .r_o(yr));

  pdre_qmul #(.WA(29), .WB(pdre_pkg::W_XD), .WR(pdre_pkg::W_FXD)) u_mul_fx (
    .clk_i(clk_i), .en_i(en), .a_i($signed({1'b0, focal_x_q})), .b_i(xd_q), .r_o(fxd));
  pdre_qmul #(.WA(29), .WB(pdre_pkg::W_XD), .WR(pdre_pkg::W_FXD)) u_mul_fy (
    .clk_i(clk_i), .en_i(en), .a_i($signed({1'b0, focal_y_q})), .b_i(yd_q), .r_o(fyd));

  always_comb begin
    ecol = pdre_pkg::W_PX'($signed({1'b0, sd_q[LAT-2].col, 16'h0000}))
         - pdre_pkg::W_PX'($signed({1'b0, center_x_q})) - pdre_pkg::W_PX'(fxd);
    erow = pdre_pkg::W_PX'($signed({1'b0, sd_q[LAT-2].row, 16'h0000}))
         - pdre_pkg::W_PX'($signed({1'b0, center_y_q})) - pdre_pkg::W_PX'(fyd);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lmag_q   <= lmag_c;
      umag_q   <= umag_c;
      dmag_q   <= dmag_c;
      sd_q[0]  <= side_c;
      for (int k = 1; k < LAT - 1; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      x_q <= pdre_pkg::sat_quot(quo_x, ovf_x, sd_q[DS].negx);
      y_q <= pdre_pkg::sat_quot(quo_y, ovf_y, sd_q[DS].negy);
      xyc_q[0] <= '{x: x_q, y: y_q};
      for (int k = 1; k < 8; k++) begin
        xyc_q[k] <= xyc_q[k-1];
      end
      r2_q <= r2_d;
      tx_q <= tx_d;
      ty_q <= ty_d;
      xy_q <= xy;
      k1r2_q[0] <= k1r2;
      k1r2_q[1] <= k1r2_q[0];
      tg_q[0] <= '{p1xy: p1xy, p2xy: p2xy, p2tx: p2tx, p1ty: p1ty};
      for (int k = 1; k < 5; k++) begin
        tg_q[k] <= tg_q[k-1];
      end
      radial_q <= pdre_pkg::W_RAD'(1 <<< QF) + pdre_pkg::W_RAD'(k1r2_q[1])
                + pdre_pkg::W_RAD'(k2r4);
      xd_q <= pdre_pkg::W_XD'(xr) + (pdre_pkg::W_XD'(tg_q[4].p1xy) <<< 1)
            + pdre_pkg::W_XD'(tg_q[4].p2tx);
      yd_q <= pdre_pkg::W_XD'(yr) + (pdre_pkg::W_XD'(tg_q[4].p2xy) <<< 1)
            + pdre_pkg::W_XD'(tg_q[4].p1ty);
      zero_q    <= sd_q[LAT-2].zero;
      err_col_q <= sd_q[LAT-2].zero ? '0 : pdre_pkg::sat32(ecol);
      err_row_q <= sd_q[LAT-2].zero ? '0 : pdre_pkg::sat32(erow);
    end
  end

  assign out_valid_o  = v_q[LAT-1];
  assign err_col_o    = err_col_q;
  assign err_row_o    = err_row_q;
  assign depth_zero_o = zero_q;

`ifndef NO_ASSERTIONS
  a_zero_forces_errors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_zero_o) |-> (err_col_o == '0 && err_row_o == '0))
    else $error("zero depth result carries nonzero errors");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(v_q))
    else $error("pipeline moved while the result was held");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");
`endif

endmodule
